>>> src/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = ROWS * COLUMNS;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned ADDR_W  = 11;
  localparam int unsigned CELL_W  = 16;

  // Print rules
  localparam int unsigned TAB_STEP   = 8;
  localparam logic [7:0]  CH_BS      = 8'h08;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  CH_LAST    = 8'h7F;
  localparam logic [7:0]  RESET_ATTR = 8'h0F;

  typedef enum logic [1:0] {
    OP_PRINT = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [7:0]        char_code;
    logic [ADDR_W-1:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_position;
    logic [CELL_W-1:0] cell_value;
  } tcw_out_t;

endpackage

>>> src/tcw_ram.sv
module tcw_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/text_console_writer_unit.sv
// Items are taken one at a time. Print without scroll, read cell and no-op pass from the input
// beat to the result state, then load into the output register once it is free. A clear homes
// the cursor and fills every cell with attribute and space, one cell store write per cycle. A
// scroll moves rows up; the row copy and bottom row fill share the single write port.
// Reset: cursor homes, attribute becomes 0x0F and a pass over every cell blanks the
// store to 0x0F20; no input beat is taken during that pass, configuration beats are.
module text_console_writer_unit
  import tcw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tcw_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output tcw_out_t    out_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COPY = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'((ROWS - 1) * COLUMNS);

  logic [1:0]        state_q, state_d;
  logic              init_q, init_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [CELL_W-1:0] fill_val_q, fill_val_d;
  logic              cp_vld_q, cp_vld_d;
  logic [ADDR_W-1:0] cp_addr_q, cp_addr_d;
  logic              rd_sel_q, rd_sel_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [7:0]        attr_q;
  logic              out_valid_q;
  tcw_out_t          out_data_q;

  logic              in_beat;
  logic              out_free;
  logic [ADDR_W-1:0] cur_addr;
  logic [COL_W:0]    col_n;
  logic              new_line;
  logic              printable;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cur_addr    = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q));

  // Next cursor column for a printed byte
  always_comb begin
    col_n     = {1'b0, col_q};
    new_line  = 1'b0;
    printable = (in_data_i.char_code inside {[CH_SPACE:CH_LAST]});
    case (in_data_i.char_code)
      CH_BS: begin
        if (col_q != '0) col_n = {1'b0, col_q} - 1'b1;
      end
      CH_TAB: begin
        col_n = ({1'b0, col_q} + (COL_W+1)'(TAB_STEP)) & ~((COL_W+1)'(TAB_STEP - 1));
      end
      CH_CR: col_n = '0;
      CH_LF: new_line = 1'b1;
      default: begin
        if (printable) col_n = {1'b0, col_q} + 1'b1;
      end
    endcase
    if (col_n >= (COL_W+1)'(COLUMNS)) new_line = 1'b1;
  end

  // Sequencer and cell store port control
  always_comb begin
    state_d    = state_q;
    init_d     = init_q;
    ptr_d      = ptr_q;
    fill_val_d = fill_val_q;
    cp_vld_d   = 1'b0;
    cp_addr_d  = cp_addr_q;
    rd_sel_d   = rd_sel_q;
    col_d      = col_q;
    row_d      = row_q;
    ram_we     = 1'b0;
    ram_waddr  = ptr_q;
    ram_wdata  = fill_val_q;
    ram_re     = 1'b0;
    ram_raddr  = ptr_q;

    // Drain the copy pipeline first
    if (cp_vld_q) begin
      ram_we    = 1'b1;
      ram_waddr = cp_addr_q;
      ram_wdata = ram_rdata;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          rd_sel_d = 1'b0;
          state_d  = ST_RESP;
          case (in_data_i.opcode)
            OP_PRINT: begin
              if (printable) begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {attr_q, in_data_i.char_code};
              end
              col_d = col_n[COL_W-1:0];
              if (new_line) begin
                col_d = '0;
                if (row_q == ROW_W'(ROWS - 1)) begin
                  state_d = ST_COPY;
                  ptr_d   = ADDR_W'(COLUMNS);
                end else begin
                  row_d = row_q + 1'b1;
                end
              end
            end
            OP_CLEAR: begin
              col_d      = '0;
              row_d      = '0;
              ptr_d      = '0;
              fill_val_d = {attr_q, CH_SPACE};
              state_d    = ST_FILL;
            end
            OP_READ: begin
              if (in_data_i.cell_index < ADDR_W'(CELLS)) begin
                ram_re    = 1'b1;
                ram_raddr = in_data_i.cell_index;
                rd_sel_d  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_COPY: begin
        // Read one row ahead, write back in the next cycle
        ram_re    = 1'b1;
        ram_raddr = ptr_q;
        cp_vld_d  = 1'b1;
        cp_addr_d = ptr_q - ADDR_W'(COLUMNS);
        if (ptr_q == LAST_CELL) begin
          ptr_d      = BOTTOM_ROW;
          fill_val_d = {attr_q, CH_SPACE};
          state_d    = ST_FILL;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_FILL: begin
        if (!cp_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q;
          ram_wdata = fill_val_q;
          if (ptr_q == LAST_CELL) begin
            init_d  = 1'b0;
            state_d = init_q ? ST_IDLE : ST_RESP;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      init_q     <= 1'b1;
      ptr_q      <= '0;
      fill_val_q <= {RESET_ATTR, CH_SPACE};
      cp_vld_q   <= 1'b0;
      rd_sel_q   <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      attr_q     <= RESET_ATTR;
    end else begin
      state_q    <= state_d;
      init_q     <= init_d;
      ptr_q      <= ptr_d;
      fill_val_q <= fill_val_d;
      cp_vld_q   <= cp_vld_d;
      rd_sel_q   <= rd_sel_d;
      col_q      <= col_d;
      row_q      <= row_d;
      if (cfg_valid_i && cfg_ready_o) attr_q <= cfg_data_i;
    end
  end

  // Payload register for the copy write address
  always_ff @(posedge clk_i) begin
    cp_addr_q <= cp_addr_d;
  end

  // Output register: load the result beat when the slot is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_RESP && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESP && out_free) begin
      out_data_q.cursor_position <= cur_addr;
      out_data_q.cell_value      <= rd_sel_q ? ram_rdata : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  tcw_ram #(
    .DEPTH (CELLS),
    .WIDTH (CELL_W)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Cursor stays on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q < COL_W'(COLUMNS)) && (row_q < ROW_W'(ROWS)))
    else $error("cursor off screen");

  // No copy write may be pending while items are taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cp_vld_q)
    else $error("copy write pending in idle");

  // A read never targets the cell being written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_re && ram_we) |-> (ram_raddr != ram_waddr))
    else $error("cell store read and write collide");

  // A read beat goes straight to the result stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && in_data_i.opcode == OP_READ) |=> (state_q == ST_RESP))
    else $error("read item did not reach result stage");

endmodule
